[hdl/alle_pkg.sv]
package alle_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int OPCODE_W = 4;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;

   // Opcodes carried by a request transaction.
   localparam logic [OPCODE_W-1:0] OP_INSERT_BEFORE = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT_BACK   = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT_FRONT  = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_SLOT   = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_FRONT  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_BACK   = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_GET           = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_NEXT          = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_PREV          = 4'd8;

   // Status codes returned in a response transaction.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POSITION  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // One response transaction.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  data_out;
      logic [SLOT_W-1:0]   slot_out;
      logic [SLOT_W-1:0]   head_slot;
      logic [SLOT_W-1:0]   tail_slot;
      logic [SLOT_W-1:0]   count;
   } rsp_type;

endpackage

[hdl/alle_ram.sv]
module alle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/alle_rsp_buf.sv]
module alle_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  alle_pkg::rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output alle_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   alle_pkg::rsp_type data_ff;

   // The slot is free when empty or when its transaction leaves this cycle.
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[hdl/alle_ctrl.sv]
module alle_ctrl #(
   parameter int CAPACITY = 255,
   parameter int ELEMENT_WIDTH = 64,
   localparam int NSLOTS = CAPACITY + 1,
   localparam int IW = $clog2(NSLOTS),
   localparam int LW = $clog2(NSLOTS + 1),
   localparam int EW = ELEMENT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [alle_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [alle_pkg::POS_W-1:0]     req_position,
   input  logic [alle_pkg::VALUE_W-1:0]   req_value,
   output logic                           rsp_push,
   input  logic                           rsp_space,
   output alle_pkg::rsp_type              rsp_result,
   output logic                           fwd_wr_en,
   output logic [IW-1:0]                  fwd_wr_addr,
   output logic [LW-1:0]                  fwd_wr_data,
   output logic [IW-1:0]                  fwd_rd_addr,
   input  logic [LW-1:0]                  fwd_rd_data,
   output logic                           bwd_wr_en,
   output logic [IW-1:0]                  bwd_wr_addr,
   output logic [LW-1:0]                  bwd_wr_data,
   output logic [IW-1:0]                  bwd_rd_addr,
   input  logic [LW-1:0]                  bwd_rd_data,
   output logic                           elem_wr_en,
   output logic [IW-1:0]                  elem_wr_addr,
   output logic [EW-1:0]                  elem_wr_data,
   output logic [IW-1:0]                  elem_rd_addr,
   input  logic [EW-1:0]                  elem_rd_data
);

   localparam int PW   = alle_pkg::POS_W;
   localparam int VW   = alle_pkg::VALUE_W;
   localparam int SW   = alle_pkg::SLOT_W;
   localparam int CMPW = (IW > PW) ? IW : PW;

   typedef enum logic [12:0] {
      ST_INIT  = 13'b0_0000_0000_0001,
      ST_IDLE  = 13'b0_0000_0000_0010,
      ST_CHECK = 13'b0_0000_0000_0100,
      ST_INS1  = 13'b0_0000_0000_1000,
      ST_INS2  = 13'b0_0000_0001_0000,
      ST_INS3  = 13'b0_0000_0010_0000,
      ST_RM1   = 13'b0_0000_0100_0000,
      ST_RM2   = 13'b0_0000_1000_0000,
      ST_RM3   = 13'b0_0001_0000_0000,
      ST_STEP  = 13'b0_0010_0000_0000,
      ST_ELEM  = 13'b0_0100_0000_0000,
      ST_LINK  = 13'b0_1000_0000_0000,
      ST_DONE  = 13'b1_0000_0000_0000
   } state_type;

   // Control state.
   state_type                      state_ff, state_in;
   logic [IW-1:0]                  init_ff, init_in;
   logic [IW-1:0]                  count_ff, count_in;
   logic [LW-1:0]                  free_ff, free_in;
   logic [LW-1:0]                  head_ff, head_in;
   logic [LW-1:0]                  tail_ff, tail_in;

   // Transaction payload and working registers.
   logic [alle_pkg::OPCODE_W-1:0]  op_ff, op_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [EW-1:0]                  val_ff, val_in;
   logic [LW-1:0]                  pidx_ff, pidx_in;
   logic [LW-1:0]                  q_ff, q_in;
   logic [LW-1:0]                  n_ff, n_in;
   logic [PW-1:0]                  remain_ff, remain_in;
   logic [alle_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [EW-1:0]                  data_ff, data_in;
   logic [LW-1:0]                  slot_ff, slot_in;
   logic                           fwd_oor_ff, fwd_oor_in;
   logic                           bwd_oor_ff, bwd_oor_in;
   logic                           elem_oor_ff, elem_oor_in;

   // Decoded values.
   logic [LW-1:0]                  fwd_val, bwd_val;
   logic [EW-1:0]                  elem_val;
   logic [LW-1:0]                  pos_link;
   logic [LW-1:0]                  anchor;
   logic [LW-1:0]                  victim;
   logic                           pos_gt_cnt, pos_ge_cnt;
   logic                           is_full;

   // True when a link value names a slot in the RAM.
   function automatic logic in_range(input logic [LW-1:0] x);
      return x <= LW'(CAPACITY);
   endfunction

   // RAM address of a link value; slots outside the RAM map to entry zero.
   function automatic logic [IW-1:0] addr_of(input logic [LW-1:0] x);
      return in_range(x) ? x[IW-1:0] : '0;
   endfunction

   // Reads of a slot outside the RAM return zero.
   assign fwd_val  = fwd_oor_ff  ? '0 : fwd_rd_data;
   assign bwd_val  = bwd_oor_ff  ? '0 : bwd_rd_data;
   assign elem_val = elem_oor_ff ? '0 : elem_rd_data;

   // Operand selection and checks on the latched request.
   assign pos_link   = LW'(pos_ff);
   assign pos_gt_cnt = CMPW'(pos_ff) >  CMPW'(count_ff);
   assign pos_ge_cnt = CMPW'(pos_ff) >= CMPW'(count_ff);
   assign is_full    = (count_ff >= IW'(CAPACITY)) || (free_ff == '0)
                       || (free_ff > LW'(CAPACITY));

   always_comb begin
      case (op_ff) inside
         alle_pkg::OP_INSERT_BEFORE: anchor = pos_link;
         alle_pkg::OP_INSERT_FRONT:  anchor = head_ff;
         default:                    anchor = '0;
      endcase
      case (op_ff) inside
         alle_pkg::OP_REMOVE_SLOT:  victim = pos_link;
         alle_pkg::OP_REMOVE_FRONT: victim = head_ff;
         default:                   victim = tail_ff;
      endcase
   end

   // Sequencer: each state issues at most one read and one write per RAM.
   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      count_in    = count_ff;
      free_in     = free_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      pidx_in     = pidx_ff;
      q_in        = q_ff;
      n_in        = n_ff;
      remain_in   = remain_ff;
      status_in   = status_ff;
      data_in     = data_ff;
      slot_in     = slot_ff;
      fwd_oor_in  = 1'b1;
      bwd_oor_in  = 1'b1;
      elem_oor_in = 1'b1;

      fwd_wr_en    = 1'b0;
      fwd_wr_addr  = '0;
      fwd_wr_data  = '0;
      fwd_rd_addr  = '0;
      bwd_wr_en    = 1'b0;
      bwd_wr_addr  = '0;
      bwd_wr_data  = '0;
      bwd_rd_addr  = '0;
      elem_wr_en   = 1'b0;
      elem_wr_addr = '0;
      elem_wr_data = '0;
      elem_rd_addr = '0;

      req_ready = 1'b0;
      rsp_push  = 1'b0;

      unique case (state_ff)
         // Write the reset chain into both link RAMs, one slot per cycle.
         ST_INIT: begin
            fwd_wr_en   = 1'b1;
            fwd_wr_addr = init_ff;
            fwd_wr_data = (init_ff == '0) ? '0 : LW'(init_ff) + LW'(1);
            bwd_wr_en   = 1'b1;
            bwd_wr_addr = init_ff;
            bwd_wr_data = (init_ff == '0) ? '0 : LW'(init_ff) - LW'(1);
            if (init_ff == IW'(CAPACITY)) begin
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               pos_in   = req_position;
               val_in   = req_value[EW-1:0];
               state_in = ST_CHECK;
            end
         end

         // Check the request and issue the first reads.
         ST_CHECK: begin
            status_in = alle_pkg::STATUS_OK;
            data_in   = '0;
            slot_in   = '0;
            state_in  = ST_DONE;
            case (op_ff) inside
               alle_pkg::OP_INSERT_BEFORE, alle_pkg::OP_INSERT_BACK,
               alle_pkg::OP_INSERT_FRONT: begin
                  if ((op_ff == alle_pkg::OP_INSERT_BEFORE) && pos_gt_cnt) begin
                     status_in = alle_pkg::STATUS_POSITION;
                  end else if (is_full) begin
                     status_in = alle_pkg::STATUS_FULL;
                  end else begin
                     pidx_in     = free_ff;
                     fwd_rd_addr = addr_of(free_ff);
                     fwd_oor_in  = !in_range(free_ff);
                     bwd_rd_addr = addr_of(anchor);
                     bwd_oor_in  = !in_range(anchor);
                     state_in    = ST_INS1;
                  end
               end
               alle_pkg::OP_REMOVE_SLOT, alle_pkg::OP_REMOVE_FRONT,
               alle_pkg::OP_REMOVE_BACK: begin
                  if (count_ff == '0) begin
                     status_in = alle_pkg::STATUS_UNDERFLOW;
                  end else if ((op_ff == alle_pkg::OP_REMOVE_SLOT)
                               && ((pos_ff == '0) || pos_gt_cnt)) begin
                     status_in = alle_pkg::STATUS_POSITION;
                  end else begin
                     pidx_in      = victim;
                     fwd_rd_addr  = addr_of(victim);
                     fwd_oor_in   = !in_range(victim);
                     bwd_rd_addr  = addr_of(victim);
                     bwd_oor_in   = !in_range(victim);
                     elem_rd_addr = addr_of(victim);
                     elem_oor_in  = !in_range(victim);
                     state_in     = ST_RM1;
                  end
               end
               alle_pkg::OP_GET: begin
                  if (pos_ge_cnt) begin
                     status_in = alle_pkg::STATUS_POSITION;
                  end else if (pos_ff == '0) begin
                     elem_rd_addr = addr_of(head_ff);
                     elem_oor_in  = !in_range(head_ff);
                     state_in     = ST_ELEM;
                  end else begin
                     fwd_rd_addr = addr_of(head_ff);
                     fwd_oor_in  = !in_range(head_ff);
                     remain_in   = pos_ff;
                     state_in    = ST_STEP;
                  end
               end
               alle_pkg::OP_NEXT, alle_pkg::OP_PREV: begin
                  if (pos_gt_cnt) begin
                     status_in = alle_pkg::STATUS_POSITION;
                  end else begin
                     fwd_rd_addr = addr_of(pos_link);
                     fwd_oor_in  = !in_range(pos_link);
                     bwd_rd_addr = addr_of(pos_link);
                     bwd_oor_in  = !in_range(pos_link);
                     state_in    = ST_LINK;
                  end
               end
               default: begin
                  status_in = alle_pkg::STATUS_OK;
               end
            endcase
         end

         // Insert: pop the free slot, store the element, fetch the successor of q.
         ST_INS1: begin
            free_in      = fwd_val;
            q_in         = bwd_val;
            elem_wr_en   = 1'b1;
            elem_wr_addr = pidx_ff[IW-1:0];
            elem_wr_data = val_ff;
            fwd_rd_addr  = addr_of(bwd_val);
            fwd_oor_in   = !in_range(bwd_val);
            state_in     = ST_INS2;
         end

         // Insert: link the new slot to its neighbors.
         ST_INS2: begin
            fwd_wr_en   = 1'b1;
            fwd_wr_addr = pidx_ff[IW-1:0];
            fwd_wr_data = fwd_val;
            bwd_wr_en   = 1'b1;
            bwd_wr_addr = pidx_ff[IW-1:0];
            bwd_wr_data = q_ff;
            n_in        = (q_ff == pidx_ff) ? pidx_ff : fwd_val;
            state_in    = ST_INS3;
         end

         // Insert: point the neighbors at the new slot.
         ST_INS3: begin
            fwd_wr_en   = in_range(q_ff);
            fwd_wr_addr = addr_of(q_ff);
            fwd_wr_data = pidx_ff;
            bwd_wr_en   = in_range(n_ff);
            bwd_wr_addr = addr_of(n_ff);
            bwd_wr_data = pidx_ff;
            count_in    = count_ff + 1'b1;
            slot_in     = pidx_ff;
            state_in    = ST_DONE;
         end

         // Remove: bridge the neighbors around the slot.
         ST_RM1: begin
            data_in     = elem_val;
            fwd_wr_en   = in_range(bwd_val);
            fwd_wr_addr = addr_of(bwd_val);
            fwd_wr_data = fwd_val;
            bwd_wr_en   = in_range(fwd_val);
            bwd_wr_addr = addr_of(fwd_val);
            bwd_wr_data = bwd_val;
            state_in    = ST_RM2;
         end

         // Remove: push the slot onto the free chain.
         ST_RM2: begin
            fwd_wr_en   = in_range(pidx_ff);
            fwd_wr_addr = addr_of(pidx_ff);
            fwd_wr_data = free_ff;
            bwd_wr_en   = (count_ff < IW'(CAPACITY)) && in_range(free_ff);
            bwd_wr_addr = addr_of(free_ff);
            bwd_wr_data = pidx_ff;
            state_in    = ST_RM3;
         end

         // Remove: the freed slot's back link takes the current tail.
         ST_RM3: begin
            bwd_wr_en   = in_range(pidx_ff);
            bwd_wr_addr = addr_of(pidx_ff);
            bwd_wr_data = tail_ff;
            free_in     = pidx_ff;
            count_in    = count_ff - 1'b1;
            state_in    = ST_DONE;
         end

         // Get: follow one forward link per cycle.
         ST_STEP: begin
            if (remain_ff == PW'(1)) begin
               elem_rd_addr = addr_of(fwd_val);
               elem_oor_in  = !in_range(fwd_val);
               state_in     = ST_ELEM;
            end else begin
               fwd_rd_addr = addr_of(fwd_val);
               fwd_oor_in  = !in_range(fwd_val);
               remain_in   = remain_ff - 1'b1;
            end
         end

         ST_ELEM: begin
            data_in  = elem_val;
            state_in = ST_DONE;
         end

         ST_LINK: begin
            slot_in  = (op_ff == alle_pkg::OP_NEXT) ? fwd_val : bwd_val;
            state_in = ST_DONE;
         end

         // Hand the result to the response register.
         ST_DONE: begin
            rsp_push = rsp_space;
            if (rsp_space) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Head and tail mirror the sentinel's links; every write to slot zero updates them.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (fwd_wr_en && (fwd_wr_addr == '0)) begin
         head_in = fwd_wr_data;
      end
      if (bwd_wr_en && (bwd_wr_addr == '0)) begin
         tail_in = bwd_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff  <= '0;
         count_ff <= '0;
         free_ff  <= LW'(1);
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      pidx_ff     <= pidx_in;
      q_ff        <= q_in;
      n_ff        <= n_in;
      remain_ff   <= remain_in;
      status_ff   <= status_in;
      data_ff     <= data_in;
      slot_ff     <= slot_in;
      fwd_oor_ff  <= fwd_oor_in;
      bwd_oor_ff  <= bwd_oor_in;
      elem_oor_ff <= elem_oor_in;
   end

   // Response fields reflect the list after the operation.
   always_comb begin
      rsp_result.status    = status_ff;
      rsp_result.data_out  = VW'(data_ff);
      rsp_result.slot_out  = SW'(slot_ff);
      rsp_result.head_slot = SW'(head_ff);
      rsp_result.tail_slot = SW'(tail_ff);
      rsp_result.count     = SW'(count_ff);
   end

endmodule

[hdl/array_linked_list_engine_core.sv]
// A request is checked first; an error or unknown opcode goes straight to the done state, next/prev
// read both links, insert and remove run their link-update states, and get steps down the forward links.
// One transaction is worked at a time; the next request is taken once the result is registered
// and the sequencer is back in idle, and the done state waits while the response register is full.
// Get follows one forward link per cycle. Reset (synchronous) starts a pass over all
// CAPACITY + 1 slots that builds the free chain in the link RAMs; req_ready is low then.
module array_linked_list_engine_core #(
   parameter int CAPACITY = 255,
   parameter int ELEMENT_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [alle_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [alle_pkg::POS_W-1:0]    req_position,
   input  logic [alle_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [alle_pkg::STATUS_W-1:0] rsp_status,
   output logic [alle_pkg::VALUE_W-1:0]  rsp_data_out,
   output logic [alle_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [alle_pkg::SLOT_W-1:0]   rsp_head_slot,
   output logic [alle_pkg::SLOT_W-1:0]   rsp_tail_slot,
   output logic [alle_pkg::SLOT_W-1:0]   rsp_count
);

   localparam int NSLOTS = CAPACITY + 1;
   localparam int IW = $clog2(NSLOTS);
   localparam int LW = $clog2(NSLOTS + 1);
   localparam int EW = ELEMENT_WIDTH;

   logic              fwd_wr_en, bwd_wr_en, elem_wr_en;
   logic [IW-1:0]     fwd_wr_addr, bwd_wr_addr, elem_wr_addr;
   logic [IW-1:0]     fwd_rd_addr, bwd_rd_addr, elem_rd_addr;
   logic [LW-1:0]     fwd_wr_data, bwd_wr_data;
   logic [LW-1:0]     fwd_rd_data, bwd_rd_data;
   logic [EW-1:0]     elem_wr_data, elem_rd_data;
   logic              rsp_push, rsp_space;
   alle_pkg::rsp_type rsp_result, rsp_data;

   // Forward links: entry zero is the head of the list.
   alle_ram #(.WIDTH(LW), .DEPTH(NSLOTS)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_wr_en),
      .wr_addr (fwd_wr_addr),
      .wr_data (fwd_wr_data),
      .rd_addr (fwd_rd_addr),
      .rd_data (fwd_rd_data)
   );

   // Backward links: entry zero is the tail of the list.
   alle_ram #(.WIDTH(LW), .DEPTH(NSLOTS)) u_bwd_ram (
      .clock   (clock),
      .wr_en   (bwd_wr_en),
      .wr_addr (bwd_wr_addr),
      .wr_data (bwd_wr_data),
      .rd_addr (bwd_rd_addr),
      .rd_data (bwd_rd_data)
   );

   // Element words.
   alle_ram #(.WIDTH(EW), .DEPTH(NSLOTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   alle_ctrl #(.CAPACITY(CAPACITY), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_push     (rsp_push),
      .rsp_space    (rsp_space),
      .rsp_result   (rsp_result),
      .fwd_wr_en    (fwd_wr_en),
      .fwd_wr_addr  (fwd_wr_addr),
      .fwd_wr_data  (fwd_wr_data),
      .fwd_rd_addr  (fwd_rd_addr),
      .fwd_rd_data  (fwd_rd_data),
      .bwd_wr_en    (bwd_wr_en),
      .bwd_wr_addr  (bwd_wr_addr),
      .bwd_wr_data  (bwd_wr_data),
      .bwd_rd_addr  (bwd_rd_addr),
      .bwd_rd_data  (bwd_rd_data),
      .elem_wr_en   (elem_wr_en),
      .elem_wr_addr (elem_wr_addr),
      .elem_wr_data (elem_wr_data),
      .elem_rd_addr (elem_rd_addr),
      .elem_rd_data (elem_rd_data)
   );

   // Response register between the sequencer and the result channel.
   alle_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_result),
      .space     (rsp_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status    = rsp_data.status;
   assign rsp_data_out  = rsp_data.data_out;
   assign rsp_slot_out  = rsp_data.slot_out;
   assign rsp_head_slot = rsp_data.head_slot;
   assign rsp_tail_slot = rsp_data.tail_slot;
   assign rsp_count     = rsp_data.count;

endmodule
